// ===== sv/usp_pkg.sv =====
// ----------------------------------------------------------------------------
// usp_pkg
// Shared constants, codes and record types of the uphill peak score block.
// ----------------------------------------------------------------------------
package usp_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int VA_W         = $clog2(MAX_VERTICES);
  localparam int EA_W         = $clog2(MAX_EDGES);
  localparam int VN_W         = 11;
  localparam int H_W          = 20;
  localparam int COST_W       = 20;
  localparam int DIST_W       = 40;
  localparam int CFG_W        = 16;
  localparam int SCORE_W      = 64;

  // input item kinds
  localparam logic [1:0] KIND_HEIGHT = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_VCOUNT  = 2'd0;
  localparam logic [1:0] REG_DWEIGHT = 2'd1;
  localparam logic [1:0] REG_HGAIN   = 2'd2;
  localparam logic [1:0] REG_NONE    = 2'd3;

  // per-vertex search record
  typedef struct packed {
    logic              settled;
    logic              reached;
    logic [DIST_W-1:0] plen;
  } dist_ent_t;

  // stored edge
  typedef struct packed {
    logic [VN_W-1:0]   end_a;
    logic [VN_W-1:0]   end_b;
    logic [COST_W-1:0] cost;
  } edge_ent_t;

endpackage

// ===== sv/usp_ram.sv =====
// ----------------------------------------------------------------------------
// usp_ram
// Generic single-write, single-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module usp_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/usp_score.sv =====
// ----------------------------------------------------------------------------
// usp_score
// Two-stage score pipeline: height reward minus distance penalty.
// ----------------------------------------------------------------------------
module usp_score
  import usp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [H_W-1:0]            height_i,
  input  logic [DIST_W:0]           dsum_i,
  input  logic [CFG_W-1:0]          gain_i,
  input  logic [CFG_W-1:0]          weight_i,
  output logic                      vld_o,
  output logic signed [SCORE_W-1:0] score_o
);

  localparam int PG_W = H_W + CFG_W;
  localparam int PD_W = DIST_W + 1 + CFG_W;

  logic                      vld1_r;
  logic [PG_W-1:0]           pgain_r;
  logic [PD_W-1:0]           pdist_r;
  logic                      vld2_r;
  logic signed [SCORE_W-1:0] score_r;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // products, then difference
  always_ff @(posedge clk) begin
    pgain_r <= PG_W'(height_i) * PG_W'(gain_i);
    pdist_r <= PD_W'(dsum_i) * PD_W'(weight_i);
    score_r <= $signed(SCORE_W'(pgain_r)) - $signed(SCORE_W'(pdist_r));
  end

  assign vld_o   = vld2_r;
  assign score_o = score_r;

endmodule

// ===== sv/uphill_shortest_path_peak_score.sv =====
// ----------------------------------------------------------------------------
// uphill_shortest_path_peak_score
// Stores heights and edges; a run does two uphill shortest-path searches and
// reports the best peak score over vertices 2..nv reached from both ends.
// ----------------------------------------------------------------------------
//  channel  ports                                   transfer
//  input    start/busy, in_*                        start & !busy
//  result   out_valid, out_*                        one-cycle strobe
//  config   cfg_valid/cfg_ready, cfg_index/cfg_data cfg_valid & cfg_ready
//
//  Height and edge loads are accepted back to back while idle.
//  A run does, per search, a clear of the records, a seed of the source and,
//  for each settled vertex, a sweep and a scan of the stored edges, then a
//  last sweep; scoring of the vertices follows.
//  The pace is set by the single read port of each vertex and edge memory.
//  rst_n is synchronous; the result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module uphill_shortest_path_peak_score
  import usp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_kind,
  input  logic [VN_W-1:0]     in_first_vertex,
  input  logic [VN_W-1:0]     in_second_vertex,
  input  logic [H_W-1:0]      in_height_value,
  input  logic [COST_W-1:0]   in_edge_cost,
  output logic                out_valid,
  output logic                out_possible,
  output logic signed [62:0]  out_best_score,
  output logic                out_edges_dropped,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLEAR  = 12'b000000000010,
    S_INIT   = 12'b000000000100,
    S_SEL    = 12'b000000001000,
    S_SETTLE = 12'b000000010000,
    S_HCAP   = 12'b000000100000,
    S_ERD    = 12'b000001000000,
    S_ECHK   = 12'b000010000000,
    S_EUPD   = 12'b000100000000,
    S_SCORE  = 12'b001000000000,
    S_DRAIN  = 12'b010000000000,
    S_DONE   = 12'b100000000000
  } state_t;

  localparam logic [VN_W-1:0]  NV_MAX = VN_W'(MAX_VERTICES);
  localparam logic [EA_W:0]    NE_MAX = (EA_W+1)'(MAX_EDGES);

  state_t                    st_r, st_nxt;
  logic                      srch_r, srch_nxt;
  logic [VN_W-1:0]           idx_r, idx_nxt;
  logic                      rv_r, rv_nxt;
  logic [VN_W-1:0]           nv_r, nv_nxt;
  logic [EA_W:0]             k_r, k_nxt;
  logic [EA_W:0]             eload_r, eload_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [VN_W-1:0]           vcount_r;
  logic [CFG_W-1:0]          dweight_r, hgain_r;
  logic                      found_r, found_nxt;
  logic [VA_W-1:0]           min_idx_r, min_idx_nxt;
  logic [DIST_W-1:0]         min_dist_r, min_dist_nxt;
  logic [VA_W-1:0]           cur_idx_r, cur_idx_nxt;
  logic [DIST_W-1:0]         cur_dist_r, cur_dist_nxt;
  logic [H_W-1:0]            cur_h_r, cur_h_nxt;
  logic [VA_W-1:0]           nxt_idx_r, nxt_idx_nxt;
  logic [DIST_W-1:0]         cand_r, cand_nxt;
  logic signed [SCORE_W-1:0] best_r, best_nxt;
  logic                      any_r, any_nxt;

  logic                      acc;
  logic                      h_we, e_we, d_we;
  logic [VA_W-1:0]           h_raddr, d_raddr, d_waddr;
  logic [H_W-1:0]            h_rdata;
  edge_ent_t                 e_wdata, e_rdata;
  dist_ent_t                 d_wdata, ds_rdata, dg_rdata, act_rd;
  logic [VN_W-1:0]           ea_m1, eb_m1, prev_idx;
  logic                      e_ok, hit_a, hit_b;
  logic [VA_W-1:0]           nxt_v;
  logic                      sc_vld_in, sc_vld;
  logic signed [SCORE_W-1:0] sc_score;

  assign acc       = start && !busy;
  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // memories
  assign e_wdata = '{end_a: in_first_vertex, end_b: in_second_vertex, cost: in_edge_cost};

  usp_ram #(.DEPTH(MAX_VERTICES), .WIDTH(H_W)) u_hram (
    .clk(clk), .we(h_we), .waddr(VA_W'(in_first_vertex - 1'b1)),
    .wdata(in_height_value), .raddr(h_raddr), .rdata(h_rdata)
  );

  usp_ram #(.DEPTH(MAX_EDGES), .WIDTH($bits(edge_ent_t))) u_eram (
    .clk(clk), .we(e_we), .waddr(eload_r[EA_W-1:0]), .wdata(e_wdata),
    .raddr(k_r[EA_W-1:0]), .rdata(e_rdata)
  );

  usp_ram #(.DEPTH(MAX_VERTICES), .WIDTH($bits(dist_ent_t))) u_dsram (
    .clk(clk), .we(d_we && !srch_r), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(ds_rdata)
  );

  usp_ram #(.DEPTH(MAX_VERTICES), .WIDTH($bits(dist_ent_t))) u_dgram (
    .clk(clk), .we(d_we && srch_r), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(dg_rdata)
  );

  assign act_rd = srch_r ? dg_rdata : ds_rdata;

  // score pipeline
  usp_score u_score (
    .clk(clk), .rst_n(rst_n), .vld_i(sc_vld_in), .height_i(h_rdata),
    .dsum_i({1'b0, ds_rdata.plen} + {1'b0, dg_rdata.plen}),
    .gain_i(hgain_r), .weight_i(dweight_r), .vld_o(sc_vld), .score_o(sc_score)
  );

  // edge decode against the vertex being settled
  assign ea_m1    = e_rdata.end_a - 1'b1;
  assign eb_m1    = e_rdata.end_b - 1'b1;
  assign e_ok     = (e_rdata.end_a != '0) && (e_rdata.end_a <= nv_r) &&
                    (e_rdata.end_b != '0) && (e_rdata.end_b <= nv_r);
  assign hit_a    = e_ok && (ea_m1 == VN_W'(cur_idx_r));
  assign hit_b    = e_ok && (eb_m1 == VN_W'(cur_idx_r));
  assign nxt_v    = hit_a ? eb_m1[VA_W-1:0] : ea_m1[VA_W-1:0];
  assign prev_idx = idx_r - 1'b1;

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    srch_nxt     = srch_r;
    idx_nxt      = idx_r;
    rv_nxt       = rv_r;
    nv_nxt       = nv_r;
    k_nxt        = k_r;
    eload_nxt    = eload_r;
    ovf_nxt      = ovf_r;
    found_nxt    = found_r;
    min_idx_nxt  = min_idx_r;
    min_dist_nxt = min_dist_r;
    cur_idx_nxt  = cur_idx_r;
    cur_dist_nxt = cur_dist_r;
    cur_h_nxt    = cur_h_r;
    nxt_idx_nxt  = nxt_idx_r;
    cand_nxt     = cand_r;
    best_nxt     = best_r;
    any_nxt      = any_r;
    h_we         = 1'b0;
    e_we         = 1'b0;
    d_we         = 1'b0;
    d_waddr      = idx_r[VA_W-1:0];
    d_wdata      = '0;
    h_raddr      = idx_r[VA_W-1:0];
    d_raddr      = idx_r[VA_W-1:0];
    sc_vld_in    = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (acc) begin
          case (in_kind)
            KIND_HEIGHT: begin
              h_we = (in_first_vertex != '0) && (in_first_vertex <= NV_MAX);
            end
            KIND_EDGE: begin
              if (eload_r < NE_MAX) begin
                e_we      = 1'b1;
                eload_nxt = eload_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            KIND_RUN: begin
              nv_nxt   = (vcount_r > NV_MAX) ? NV_MAX : vcount_r;
              any_nxt  = 1'b0;
              srch_nxt = 1'b0;
              idx_nxt  = '0;
              st_nxt   = (vcount_r < VN_W'(2)) ? S_DONE : S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      // wipe the active search records
      S_CLEAR: begin
        d_we = 1'b1;
        if (idx_r == nv_r - 1'b1) begin
          st_nxt = S_INIT;
        end
        idx_nxt = idx_r + 1'b1;
      end
      // seed the source vertex
      S_INIT: begin
        d_we      = 1'b1;
        d_waddr   = srch_r ? VA_W'(nv_r - 1'b1) : '0;
        d_wdata   = '{settled: 1'b0, reached: 1'b1, plen: '0};
        idx_nxt   = '0;
        rv_nxt    = 1'b0;
        found_nxt = 1'b0;
        st_nxt    = S_SEL;
      end
      // sweep for the nearest open vertex
      S_SEL: begin
        if (idx_r < nv_r) begin
          rv_nxt  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r && act_rd.reached && !act_rd.settled &&
            (!found_r || act_rd.plen < min_dist_r)) begin
          found_nxt    = 1'b1;
          min_idx_nxt  = prev_idx[VA_W-1:0];
          min_dist_nxt = act_rd.plen;
        end
        if (rv_r && idx_r == nv_r) begin
          st_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (!found_r) begin
          idx_nxt = srch_r ? VN_W'(1) : '0;
          rv_nxt  = 1'b0;
          if (!srch_r) begin
            srch_nxt = 1'b1;
            st_nxt   = S_CLEAR;
          end else begin
            st_nxt = S_SCORE;
          end
        end else begin
          d_we         = 1'b1;
          d_waddr      = min_idx_r;
          d_wdata      = '{settled: 1'b1, reached: 1'b1, plen: min_dist_r};
          h_raddr      = min_idx_r;
          cur_idx_nxt  = min_idx_r;
          cur_dist_nxt = min_dist_r;
          st_nxt       = S_HCAP;
        end
      end
      S_HCAP: begin
        cur_h_nxt = h_rdata;
        k_nxt     = '0;
        if (eload_r == '0) begin
          idx_nxt   = '0;
          rv_nxt    = 1'b0;
          found_nxt = 1'b0;
          st_nxt    = S_SEL;
        end else begin
          st_nxt = S_ERD;
        end
      end
      S_ERD: begin
        st_nxt = S_ECHK;
      end
      // edge touching the settled vertex: fetch the far end
      S_ECHK: begin
        if (hit_a || hit_b) begin
          h_raddr     = nxt_v;
          d_raddr     = nxt_v;
          nxt_idx_nxt = nxt_v;
          cand_nxt    = cur_dist_r + DIST_W'(e_rdata.cost);
          st_nxt      = S_EUPD;
        end else begin
          k_nxt = k_r + 1'b1;
          if (k_r + 1'b1 == eload_r) begin
            idx_nxt   = '0;
            rv_nxt    = 1'b0;
            found_nxt = 1'b0;
            st_nxt    = S_SEL;
          end else begin
            st_nxt = S_ERD;
          end
        end
      end
      // uphill relax
      S_EUPD: begin
        if (cur_h_r < h_rdata && (!act_rd.reached || cand_r < act_rd.plen)) begin
          d_we    = 1'b1;
          d_waddr = nxt_idx_r;
          d_wdata = '{settled: act_rd.settled, reached: 1'b1, plen: cand_r};
        end
        k_nxt = k_r + 1'b1;
        if (k_r + 1'b1 == eload_r) begin
          idx_nxt   = '0;
          rv_nxt    = 1'b0;
          found_nxt = 1'b0;
          st_nxt    = S_SEL;
        end else begin
          st_nxt = S_ERD;
        end
      end
      // feed vertices 2..nv to the score pipeline
      S_SCORE: begin
        if (idx_r < nv_r) begin
          rv_nxt  = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        sc_vld_in = rv_r && ds_rdata.reached && dg_rdata.reached;
        if (rv_r && idx_r == nv_r) begin
          idx_nxt = '0;
          st_nxt  = S_DRAIN;
        end
      end
      S_DRAIN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_r == VN_W'(2)) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    // running maximum
    if (sc_vld && (!any_r || sc_score > best_r)) begin
      best_nxt = sc_score;
      any_nxt  = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      eload_r   <= '0;
      ovf_r     <= 1'b0;
      any_r     <= 1'b0;
      rv_r      <= 1'b0;
      srch_r    <= 1'b0;
      vcount_r  <= VN_W'(2);
      dweight_r <= CFG_W'(1);
      hgain_r   <= CFG_W'(1);
    end else begin
      st_r    <= st_nxt;
      eload_r <= eload_nxt;
      ovf_r   <= ovf_nxt;
      any_r   <= any_nxt;
      rv_r    <= rv_nxt;
      srch_r  <= srch_nxt;
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VCOUNT:  vcount_r  <= cfg_data[VN_W-1:0];
          REG_DWEIGHT: dweight_r <= cfg_data;
          REG_HGAIN:   hgain_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    nv_r       <= nv_nxt;
    k_r        <= k_nxt;
    found_r    <= found_nxt;
    min_idx_r  <= min_idx_nxt;
    min_dist_r <= min_dist_nxt;
    cur_idx_r  <= cur_idx_nxt;
    cur_dist_r <= cur_dist_nxt;
    cur_h_r    <= cur_h_nxt;
    nxt_idx_r  <= nxt_idx_nxt;
    cand_r     <= cand_nxt;
    best_r     <= best_nxt;
  end

  // result strobe
  assign out_valid         = (st_r == S_DONE);
  assign out_possible      = any_r;
  assign out_best_score    = any_r ? best_r[62:0] : '0;
  assign out_edges_dropped = ovf_r;

endmodule

// ===== verif/uphill_shortest_path_peak_score_tb.sv =====
// ----------------------------------------------------------------------------
// uphill_shortest_path_peak_score_tb
// Drives height loads, edge loads and runs into the peak score block and
// compares every result against an in-bench uphill shortest-path predictor.
// ----------------------------------------------------------------------------
module uphill_shortest_path_peak_score_tb;
  import usp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 40_000_000;

  // expected peak score record
  typedef struct {
    logic        possible;
    logic [62:0] score;
    logic        dropped;
  } peak_result_t;

  // scoreboard: keeps its own copy of the block state and predicts each run
  class peak_score_board;
    int unsigned   vcount;
    int unsigned   dweight;
    int unsigned   hgain;
    int unsigned   heights[MAX_VERTICES+1];
    int unsigned   ea[$];
    int unsigned   eb[$];
    int unsigned   ecost[$];
    bit            overflow;
    int            failures;
    peak_result_t  score_queue[$];

    function new();
      vcount = 2;
      dweight = 1;
      hgain = 1;
      overflow = 0;
      failures = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_VCOUNT:  vcount = data[VN_W-1:0];
        REG_DWEIGHT: dweight = data;
        REG_HGAIN:   hgain = data;
        default: ;
      endcase
    endfunction

    // uphill dijkstra from src over vertices 1..nv
    function void uphill_paths(int unsigned nv, int unsigned src,
                               ref longint unsigned plen[MAX_VERTICES+1],
                               ref bit seen[MAX_VERTICES+1]);
      bit          done[MAX_VERTICES+1];
      int unsigned cur;
      int unsigned nxt;
      bit          found;
      longint unsigned cand;
      for (int i = 0; i <= MAX_VERTICES; i++) begin
        plen[i] = 0;
        seen[i] = 0;
        done[i] = 0;
      end
      seen[src] = 1;
      forever begin
        found = 0;
        cur = 0;
        for (int i = 1; i <= nv; i++) begin
          if (seen[i] && !done[i] && (!found || plen[i] < plen[cur])) begin
            cur = i;
            found = 1;
          end
        end
        if (!found) break;
        done[cur] = 1;
        foreach (ea[k]) begin
          if (ea[k] < 1 || ea[k] > nv || eb[k] < 1 || eb[k] > nv) continue;
          if (ea[k] == cur) nxt = eb[k];
          else if (eb[k] == cur) nxt = ea[k];
          else continue;
          if (!(heights[cur] < heights[nxt])) continue;
          cand = plen[cur] + ecost[k];
          if (!seen[nxt] || cand < plen[nxt]) begin
            plen[nxt] = cand;
            seen[nxt] = 1;
          end
        end
      end
    endfunction

    function void note_item(logic [1:0] kind, logic [VN_W-1:0] va, logic [VN_W-1:0] vb,
                            logic [H_W-1:0] hv, logic [COST_W-1:0] ec);
      longint unsigned ds[MAX_VERTICES+1];
      longint unsigned dg[MAX_VERTICES+1];
      bit              rs[MAX_VERTICES+1];
      bit              rg[MAX_VERTICES+1];
      int unsigned     nv;
      longint          best;
      longint          sc;
      bit              any;
      peak_result_t    r;
      case (kind)
        KIND_HEIGHT: if (va >= 1 && va <= MAX_VERTICES) heights[va] = hv;
        KIND_EDGE: begin
          if (ea.size() < MAX_EDGES) begin
            ea.insert(ea.size(), va);
            eb.insert(eb.size(), vb);
            ecost.insert(ecost.size(), ec);
          end else overflow = 1;
        end
        KIND_RUN: begin
          nv = (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
          any = 0;
          best = 0;
          if (nv >= 2) begin
            uphill_paths(nv, 1, ds, rs);
            uphill_paths(nv, nv, dg, rg);
            for (int i = 2; i <= nv; i++) begin
              if (!rs[i] || !rg[i]) continue;
              sc = longint'(heights[i]) * longint'(hgain)
                 - longint'(ds[i] + dg[i]) * longint'(dweight);
              if (!any || sc > best) begin
                best = sc;
                any = 1;
              end
            end
          end
          r.possible = any;
          r.score = any ? best[62:0] : '0;
          r.dropped = overflow;
          score_queue.insert(score_queue.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic possible, logic [62:0] score, logic dropped);
      peak_result_t e;
      if (score_queue.size() == 0) begin
        $display("%0t: unexpected result possible=%0b score=%0d dropped=%0b",
                 $time, possible, $signed(score), dropped);
        failures++;
        return;
      end
      e = score_queue.pop_front();
      if (possible !== e.possible) begin
        $display("%0t: possible expected %0b actual %0b", $time, e.possible, possible);
        failures++;
      end
      if (score !== e.score) begin
        $display("%0t: best_score expected %0d actual %0d", $time,
                 $signed(e.score), $signed(score));
        failures++;
      end
      if (dropped !== e.dropped) begin
        $display("%0t: edges_dropped expected %0b actual %0b", $time, e.dropped, dropped);
        failures++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_kind;
  logic [VN_W-1:0]     in_first_vertex;
  logic [VN_W-1:0]     in_second_vertex;
  logic [H_W-1:0]      in_height_value;
  logic [COST_W-1:0]   in_edge_cost;
  logic                out_valid;
  logic                out_possible;
  logic signed [62:0]  out_best_score;
  logic                out_edges_dropped;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [1:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  peak_score_board sb = new();
  longint          cycles = 0;
  int              gap_mode = 0;

  uphill_shortest_path_peak_score dut (.*);

  initial clk = 0;
  always #6 clk = ~clk;

  // result monitor and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid)
      sb.check_result(out_possible, out_best_score, out_edges_dropped);
    if (cycles > CYCLE_LIMIT) begin
      $display("uphill_shortest_path_peak_score verification failed");
      $finish;
    end
  end

  // random idle gap: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one input transfer
  task automatic send_item(logic [1:0] kind, logic [VN_W-1:0] va, logic [VN_W-1:0] vb,
                           logic [H_W-1:0] hv, logic [COST_W-1:0] ec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_first_vertex <= va;
    in_second_vertex <= vb;
    in_height_value <= hv;
    in_edge_cost <= ec;
    do @(posedge clk); while (busy);
    sb.note_item(kind, va, vb, hv, ec);
  endtask

  task automatic set_height(int unsigned v, int unsigned h);
    send_item(KIND_HEIGHT, v, $urandom(), h, $urandom());
  endtask

  task automatic add_edge(int unsigned a, int unsigned b, int unsigned c);
    send_item(KIND_EDGE, a, b, $urandom(), c);
  endtask

  task automatic do_run();
    send_item(KIND_RUN, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // let all outstanding work drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.score_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // one well-formed phase with random content and some noise
  task automatic random_phase();
    int unsigned nv;
    int unsigned lo;
    int          r;
    nv = $urandom_range(3, 12);
    write_reg(REG_VCOUNT, nv);
    r = $urandom_range(0, 9);
    write_reg(REG_DWEIGHT, (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 300));
    r = $urandom_range(0, 9);
    write_reg(REG_HGAIN, (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 3000));
    gap_mode = $urandom_range(0, 3) != 0;
    // valleys at both ends, mostly higher ground in between
    lo = $urandom_range(0, 1000);
    set_height(1, lo + $urandom_range(0, 50));
    set_height(nv, lo + $urandom_range(0, 50));
    for (int v = 2; v < nv; v++) begin
      if ($urandom_range(0, 5) == 0) set_height(v, $urandom_range(0, 20'hFFFFF));
      else set_height(v, lo + $urandom_range(1, 20'hFFFFF - lo));
    end
    repeat ($urandom_range(3, 8)) begin
      r = $urandom_range(0, 19);
      if (r == 0) add_edge($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom());
      else if (r == 1) begin
        lo = $urandom_range(1, nv);
        add_edge(lo, lo, $urandom());
      end else if (r == 2) add_edge($urandom_range(1, nv), $urandom_range(1, nv), 20'hFFFFF);
      else add_edge($urandom_range(1, nv), $urandom_range(1, nv), $urandom_range(0, 5000));
    end
    repeat ($urandom_range(1, 2)) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_item(KIND_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
      else if (r == 1) set_height($urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047),
                                  $urandom());
      do_run();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_HEIGHT;
    in_first_vertex = '0;
    in_second_vertex = '0;
    in_height_value = '0;
    in_edge_cost = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_VCOUNT;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // heights that the directed runs can reach get a value first
    for (int v = 1; v <= 16; v++) set_height(v, $urandom_range(0, 20'hFFFFF));
    set_height(MAX_VERTICES, $urandom_range(0, 20'hFFFFF));

    // directed: reset settings, extremes and ignored items
    do_run();
    set_height(1, 0);
    set_height(2, 20'hFFFFF);
    add_edge(1, 2, 20'hFFFFF);
    add_edge(2, 2, 7);
    add_edge(0, 2047, 20'hAAAAA);
    add_edge(1024, 1, 20'h55555);
    set_height(0, 20'h12345);
    set_height(2047, 20'h54321);
    send_item(KIND_UNUSED, 11'h7FF, 11'h7FF, 20'hFFFFF, 20'hFFFFF);
    do_run();
    write_reg(REG_DWEIGHT, 16'hFFFF);
    write_reg(REG_HGAIN, 16'hFFFF);
    do_run();
    write_reg(REG_NONE, 16'hFFFF);
    write_reg(REG_VCOUNT, 0);
    do_run();
    write_reg(REG_VCOUNT, 1);
    do_run();
    // largest sizes kept cheap: both ends are peaks, nothing uphill
    set_height(1, 20'hFFFFF);
    set_height(1024, 20'hFFFFF);
    write_reg(REG_VCOUNT, 1024);
    do_run();
    write_reg(REG_VCOUNT, 16'hFFFF);
    do_run();

    // random phases
    repeat (82) random_phase();

    drain();
    repeat (50) @(posedge clk);
    if (sb.failures == 0 && sb.score_queue.size() == 0)
      $display("uphill_shortest_path_peak_score verification clean");
    else
      $display("uphill_shortest_path_peak_score verification failed");
    $finish;
  end

endmodule
